// ===== src/strided_load_traffic_generator_defines.svh =====
// assertion macros shared by the strided load generator
`ifndef STRIDED_LOAD_TRAFFIC_GENERATOR_DEFINES_SVH
`define STRIDED_LOAD_TRAFFIC_GENERATOR_DEFINES_SVH

// consequent checked on the same edge as the antecedent
`define SLTG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sltg: same-cycle check failed");

// consequent checked on the edge after the antecedent
`define SLTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sltg: next-cycle check failed");

`endif

// ===== src/sltg_pkg.sv =====
// ----------------------------------------------------------------------------
// sltg_pkg
// shared widths, register indexes and reset values of the load generator
// ----------------------------------------------------------------------------
package sltg_pkg;

	localparam int ADDR_BITS_DEF  = 48;
	localparam int DELAY_BITS_DEF = 16;
	localparam int STRIDE_BITS    = 32;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 64;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_BITS-1:0] REG_START_ADDRESS     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE            = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_STREAM_SIZE       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MASK_MODE         = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MATCH_MASK        = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_HIT         = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_MISS_BEFORE = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_MISS_AFTER  = 3'd7;

	// reset values
	localparam logic [STRIDE_BITS-1:0] RST_STRIDE = 32'd64;
	localparam int                     RST_DELAY  = 1;

endpackage

// ===== src/sltg_ifs.sv =====
// ----------------------------------------------------------------------------
// sltg channel interfaces
// tick, load request and configuration write channels with valid/ready
// ----------------------------------------------------------------------------
interface sltg_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

interface sltg_load_if #(
	parameter int ADDR_BITS  = sltg_pkg::ADDR_BITS_DEF,
	parameter int DELAY_BITS = sltg_pkg::DELAY_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [ADDR_BITS-1:0]  load_address;
	logic [DELAY_BITS-1:0] wait_cycles;
	logic                  final_request;

	modport source (output valid, output load_address, output wait_cycles,
		output final_request, input ready);
	modport sink (input valid, input load_address, input wait_cycles,
		input final_request, output ready);
endinterface

interface sltg_cfg_if #(
	parameter int DATA_BITS = sltg_pkg::CFG_DATA_BITS
);
	logic                              valid;
	logic                              ready;
	logic [sltg_pkg::CFG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]              data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/sltg_wait_sel.sv =====
// ----------------------------------------------------------------------------
// sltg_wait_sel
// picks the wait and next address after an issue, flags the stream's final address
// ----------------------------------------------------------------------------
module sltg_wait_sel #(
	parameter int ADDR_BITS  = sltg_pkg::ADDR_BITS_DEF,
	parameter int DELAY_BITS = sltg_pkg::DELAY_BITS_DEF
) (
	input  logic [ADDR_BITS-1:0]             cur_addr,
	input  logic [ADDR_BITS-1:0]             start_address,
	input  logic [sltg_pkg::STRIDE_BITS-1:0] stride,
	input  logic [ADDR_BITS-1:0]             stream_size,
	input  logic                             mask_mode,
	input  logic [ADDR_BITS-1:0]             match_mask,
	input  logic [DELAY_BITS-1:0]            delay_hit,
	input  logic [DELAY_BITS-1:0]            delay_miss_before,
	input  logic [DELAY_BITS-1:0]            delay_miss_after,
	output logic [ADDR_BITS-1:0]             next_addr,
	output logic [DELAY_BITS-1:0]            wait_cycles,
	output logic                             is_last
);

	logic [ADDR_BITS-1:0]  stride_a;
	logic [ADDR_BITS-1:0]  prev_addr;
	logic [ADDR_BITS-1:0]  last_addr;
	logic                  is_first;
	logic                  miss_prev;
	logic                  miss_next;
	logic [DELAY_BITS-1:0] raw_wait;

	assign stride_a  = ADDR_BITS'(stride);
	assign next_addr = cur_addr + stride_a;
	assign prev_addr = cur_addr - stride_a;
	assign last_addr = start_address + stream_size;
	assign is_first  = (cur_addr == start_address);
	assign is_last   = (cur_addr == last_addr);
	assign miss_prev = ((cur_addr ^ prev_addr) & match_mask) != '0;
	assign miss_next = ((cur_addr ^ next_addr) & match_mask) != '0;

	// a miss towards the next address outranks a miss towards the previous one
	always_comb begin
		if (!mask_mode) begin
			raw_wait = delay_hit;
		end else if (is_first) begin
			raw_wait = delay_miss_after;
		end else if (!is_last && miss_next) begin
			raw_wait = delay_miss_before;
		end else if (miss_prev) begin
			raw_wait = delay_miss_after;
		end else begin
			raw_wait = delay_hit;
		end
	end

	// a zero delay counts as one
	assign wait_cycles = (raw_wait == '0) ? DELAY_BITS'(1) : raw_wait;

endmodule

// ===== src/strided_load_traffic_generator.sv =====
// ----------------------------------------------------------------------------
// strided_load_traffic_generator
// issues a strided stream of load addresses paced by programmable waits
// ----------------------------------------------------------------------------
// usage
//  - ticks: one word per elapsed clock tick; a word with tick low is a no-op
//  - loads: one word per issued load (address, chosen wait, final flag)
//  - cfg: register writes by index, always ready; only write while idle
//  - writing start_address restarts the stream from that address
// timing
//  - a tick word is registered in the input stage; its load word, if any,
//    is then registered in the output register, which drives loads
//  - one tick word per cycle is accepted save on a stalled issue; the address
//    adder, neighbour compares and wait mux sit between input stage and output register
// reset
//  - registers take their documented reset values, stream at start 0,
//    first issue due on the first tick
// stalls
//  - a stalled load word holds in the output register; a tick that would
//    issue waits in the input stage, non-issuing ticks still flow past
//  - once the final address is issued the block stays silent until restart
// ----------------------------------------------------------------------------
`include "strided_load_traffic_generator_defines.svh"

module strided_load_traffic_generator #(
	parameter int ADDR_BITS  = sltg_pkg::ADDR_BITS_DEF,
	parameter int DELAY_BITS = sltg_pkg::DELAY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sltg_tick_if.sink   ticks,
	sltg_load_if.source loads,
	sltg_cfg_if.sink    cfg
);

	// configuration registers
	logic [ADDR_BITS-1:0]             start_q;
	logic [sltg_pkg::STRIDE_BITS-1:0] stride_q;
	logic [ADDR_BITS-1:0]             size_q;
	logic                             mode_q;
	logic [ADDR_BITS-1:0]             mask_q;
	logic [DELAY_BITS-1:0]            dhit_q;
	logic [DELAY_BITS-1:0]            dmb_q;
	logic [DELAY_BITS-1:0]            dma_q;

	// stream state
	logic [ADDR_BITS-1:0]  addr_q;
	logic [DELAY_BITS-1:0] count_q;
	logic                  issue_due_q;
	logic                  finished_q;

	// input stage
	logic valid_s1;
	logic tick_s1;

	// output register
	logic                  out_valid_q;
	logic [ADDR_BITS-1:0]  out_addr_q;
	logic [DELAY_BITS-1:0] out_wait_q;
	logic                  out_final_q;

	logic                  cfg_we;
	logic                  restart;
	logic                  step_s1;
	logic                  emit;
	logic                  out_free;
	logic                  go_s1;
	logic [ADDR_BITS-1:0]  next_addr;
	logic [DELAY_BITS-1:0] sel_wait;
	logic                  is_last;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;
	assign restart   = cfg_we && (cfg.index == sltg_pkg::REG_START_ADDRESS);

	// a live tick in the input stage, and whether it issues a load
	assign step_s1  = valid_s1 && tick_s1 && !finished_q;
	assign emit     = step_s1 && issue_due_q;
	assign out_free = !out_valid_q || loads.ready;
	assign go_s1    = valid_s1 && (!emit || out_free);

	assign ticks.ready = !valid_s1 || go_s1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			stride_q <= sltg_pkg::RST_STRIDE;
			size_q   <= '0;
			mode_q   <= 1'b0;
			mask_q   <= '0;
			dhit_q   <= DELAY_BITS'(sltg_pkg::RST_DELAY);
			dmb_q    <= DELAY_BITS'(sltg_pkg::RST_DELAY);
			dma_q    <= DELAY_BITS'(sltg_pkg::RST_DELAY);
		end else if (cfg_we) begin
			case (cfg.index)
				sltg_pkg::REG_START_ADDRESS:     start_q  <= ADDR_BITS'(cfg.data);
				sltg_pkg::REG_STRIDE:            stride_q <= sltg_pkg::STRIDE_BITS'(cfg.data);
				sltg_pkg::REG_STREAM_SIZE:       size_q   <= ADDR_BITS'(cfg.data);
				sltg_pkg::REG_MASK_MODE:         mode_q   <= cfg.data[0];
				sltg_pkg::REG_MATCH_MASK:        mask_q   <= ADDR_BITS'(cfg.data);
				sltg_pkg::REG_DELAY_HIT:         dhit_q   <= DELAY_BITS'(cfg.data);
				sltg_pkg::REG_DELAY_MISS_BEFORE: dmb_q    <= DELAY_BITS'(cfg.data);
				sltg_pkg::REG_DELAY_MISS_AFTER:  dma_q    <= DELAY_BITS'(cfg.data);
				default: ;
			endcase
		end
	end

	// wait choice and next address for the current issue
	sltg_wait_sel #(
		.ADDR_BITS  (ADDR_BITS),
		.DELAY_BITS (DELAY_BITS)
	) u_wait_sel (
		.cur_addr          (addr_q),
		.start_address     (start_q),
		.stride            (stride_q),
		.stream_size       (size_q),
		.mask_mode         (mode_q),
		.match_mask        (mask_q),
		.delay_hit         (dhit_q),
		.delay_miss_before (dmb_q),
		.delay_miss_after  (dma_q),
		.next_addr         (next_addr),
		.wait_cycles       (sel_wait),
		.is_last           (is_last)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ticks.ready) begin
			valid_s1 <= ticks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ticks.ready) begin
			tick_s1 <= ticks.tick;
		end
	end

	// stream state: issue, then count down until the next issue falls due
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			count_q     <= DELAY_BITS'(sltg_pkg::RST_DELAY);
			issue_due_q <= 1'b1;
			finished_q  <= 1'b0;
		end else if (restart) begin
			addr_q      <= ADDR_BITS'(cfg.data);
			issue_due_q <= 1'b1;
			finished_q  <= 1'b0;
		end else if (go_s1 && step_s1) begin
			if (issue_due_q) begin
				issue_due_q <= 1'b0;
				count_q     <= sel_wait;
				addr_q      <= next_addr;
				if (is_last) begin
					finished_q <= 1'b1;
				end
			end else if (count_q <= DELAY_BITS'(1)) begin
				issue_due_q <= 1'b1;
			end else begin
				count_q <= count_q - DELAY_BITS'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			out_addr_q  <= addr_q;
			out_wait_q  <= sel_wait;
			out_final_q <= is_last;
		end
	end

	assign loads.valid         = out_valid_q;
	assign loads.load_address  = out_addr_q;
	assign loads.wait_cycles   = out_wait_q;
	assign loads.final_request = out_final_q;

	// checks
	`SLTG_ASSERT_NEXT(a_final_sets_finished, clk, arst_n, emit && go_s1 && is_last, finished_q)
	`SLTG_ASSERT_NEXT(a_issue_loads_count, clk, arst_n, emit && go_s1, !issue_due_q && count_q != '0)
	`SLTG_ASSERT_NOW(a_word_wait_nonzero, clk, arst_n, out_valid_q, out_wait_q != '0)

endmodule
